>>> src/wsd_pkg.sv
// ============================================================================
// wsd_pkg
// Shared types and constants of the WebSocket frame deframer.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    // Opcodes that the parser reacts to
    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_BIN   = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    // Length codes of the second header byte
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // Byte counts of extended length and mask key
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES   = 4'd4;

    // Event kinds
    typedef enum logic [1:0] {
        EV_BYTE  = 2'd0,
        EV_EMPTY = 2'd1,
        EV_PONG  = 2'd2,
        EV_CLOSE = 2'd3
    } t_event;

    // Parse phases, one-hot
    typedef enum logic [5:0] {
        PH_HDR0   = 6'b000001,
        PH_HDR1   = 6'b000010,
        PH_EXTLEN = 6'b000100,
        PH_MASK   = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_CLOSED = 6'b100000
    } t_phase;

    // One result item
    typedef struct packed {
        t_event     kind;
        logic [7:0] data;
        logic [3:0] opcode;
        logic       last;
        logic       fin;
    } t_result;

endpackage

`default_nettype wire

>>> src/websocket_frame_deframer.sv
// A byte passes the input register and parse logic into the result register.
// Throughput: 1 byte per cycle; the input register, the parse logic and the
// result register each advance every cycle while the master side takes results.
// Bytes that give no result pass the parser even while the output is stalled.
// Reset (i_rst_n low, synchronous): parser returns to the first header byte,
// both stream registers are emptied; no clearing pass.
// ============================================================================
// websocket_frame_deframer
// Byte-stream WebSocket frame parser with payload unmasking.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] data_byte, [11:8] frame_opcode,
                                     // [12] frame_fin, [15:13] zero
    output logic [1:0]  o_m_tuser,   // [1:0] event_kind
    output logic        o_m_tlast    // last_byte
);
    import wsd_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       res_valid;
    t_result    res;
    logic       out_free;
    logic       fire;

    // A byte is parsed when its result (if any) has room
    assign fire       = r_in_valid && (out_free || !res_valid);
    assign o_s_tready = !r_in_valid || fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wsd_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire && res_valid),
        .i_res      (res),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> src/wsd_parser.sv
// ============================================================================
// wsd_parser
// Frame parse state and the single-pass next-state / result logic per byte.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module wsd_parser (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_fire,      // commit the byte below
    input  wire  [7:0]          i_byte,
    output logic                o_res_valid, // byte gives a result
    output wsd_pkg::t_result    o_res
);
    import wsd_pkg::*;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic        r_fin,    n_fin;
    logic        r_masked, n_masked;
    logic [63:0] r_rem,    n_rem;
    logic [3:0]  r_ext,    n_ext;
    logic [31:0] r_key,    n_key;
    logic [1:0]  r_pos,    n_pos;

    // Next state and result for the byte at the input
    always_comb begin
        logic       v_len_done;
        logic       v_hdr_done;
        logic       v_end;
        logic       v_empty;
        logic [7:0] v_keyb;
        logic       v_data_op;

        n_phase  = r_phase;
        n_opcode = r_opcode;
        n_fin    = r_fin;
        n_masked = r_masked;
        n_rem    = r_rem;
        n_ext    = r_ext;
        n_key    = r_key;
        n_pos    = r_pos;

        o_res_valid  = 1'b0;
        o_res.kind   = EV_BYTE;
        o_res.data   = 8'h00;
        o_res.opcode = r_opcode;
        o_res.last   = 1'b1;
        o_res.fin    = r_fin;

        v_len_done = 1'b0;
        v_hdr_done = 1'b0;
        v_end      = 1'b0;
        v_empty    = 1'b0;
        v_data_op  = (r_opcode == OP_TEXT) || (r_opcode == OP_BIN);
        v_keyb     = 8'h00;

        unique case (r_phase)
            PH_HDR0: begin
                n_fin    = i_byte[7];
                n_opcode = i_byte[3:0];
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                n_masked = i_byte[7];
                n_key    = '0;
                n_pos    = '0;
                if ((i_byte[6:0] == LEN_EXT16) || (i_byte[6:0] == LEN_EXT64)) begin
                    n_ext   = (i_byte[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    n_rem   = '0;
                    n_phase = PH_EXTLEN;
                end else begin
                    n_rem      = {57'd0, i_byte[6:0]};
                    v_len_done = 1'b1;
                end
            end
            PH_EXTLEN: begin
                n_rem = {r_rem[55:0], i_byte};
                if (r_ext != '0) begin
                    n_ext = r_ext - 4'd1;
                end
                v_len_done = (n_ext == '0);
            end
            PH_MASK: begin
                n_key = {r_key[23:0], i_byte};
                if (r_ext != '0) begin
                    n_ext = r_ext - 4'd1;
                end
                v_hdr_done = (n_ext == '0);
            end
            PH_DATA: begin
                // key byte 0 is the first mask byte received (top of r_key)
                unique case (r_pos)
                    2'd0:    v_keyb = r_key[31:24];
                    2'd1:    v_keyb = r_key[23:16];
                    2'd2:    v_keyb = r_key[15:8];
                    default: v_keyb = r_key[7:0];
                endcase
                n_pos = r_pos + 2'd1;
                if (r_rem != '0) begin
                    n_rem = r_rem - 64'd1;
                end
                if (v_data_op) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = EV_BYTE;
                    o_res.data  = i_byte ^ v_keyb;
                    o_res.last  = (n_rem == '0);
                    if (n_rem == '0) begin
                        n_phase = PH_HDR0;
                    end
                end else begin
                    v_end = (n_rem == '0);
                end
            end
            default: begin
                // closed: every byte is dropped
            end
        endcase

        // Length known: go for the mask key or finish the header
        if (v_len_done) begin
            if (n_masked) begin
                n_ext   = KEY_BYTES;
                n_phase = PH_MASK;
            end else begin
                v_hdr_done = 1'b1;
            end
        end

        // Header complete: empty frame ends at once
        if (v_hdr_done) begin
            if (n_rem == '0) begin
                v_end   = 1'b1;
                v_empty = 1'b1;
            end else begin
                n_phase = PH_DATA;
            end
        end

        // End of frame event
        if (v_end) begin
            if (r_opcode == OP_CLOSE) begin
                n_phase     = PH_CLOSED;
                o_res_valid = 1'b1;
                o_res.kind  = EV_CLOSE;
            end else begin
                n_phase = PH_HDR0;
                if (r_opcode == OP_PING) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = EV_PONG;
                end else if (v_empty && v_data_op) begin
                    o_res_valid = 1'b1;
                    o_res.kind  = EV_EMPTY;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_fin    <= 1'b0;
            r_masked <= 1'b0;
            r_rem    <= '0;
            r_ext    <= '0;
            r_key    <= '0;
            r_pos    <= '0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_fin    <= n_fin;
            r_masked <= n_masked;
            r_rem    <= n_rem;
            r_ext    <= n_ext;
            r_key    <= n_key;
            r_pos    <= n_pos;
        end
    end

    // Close is terminal until reset
    a_closed_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLOSED) |=> (r_phase == PH_CLOSED))
        else $error("parser left the closed phase");

    // Nothing comes out once closed
    a_closed_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CLOSED) |-> !o_res_valid)
        else $error("result produced after close");

    // Payload phase always has bytes left
    a_data_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_rem != '0))
        else $error("payload phase with zero bytes remaining");

    // Payload bytes only for text and binary frames
    a_byte_opcode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == EV_BYTE)) |->
        ((o_res.opcode == OP_TEXT) || (o_res.opcode == OP_BIN)))
        else $error("payload byte from a non-data frame");

endmodule

`default_nettype wire

>>> src/wsd_out_stage.sv
// ============================================================================
// wsd_out_stage
// Result register driving the master-side stream.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,     // new result enters
    input  wire  wsd_pkg::t_result i_res,
    output logic                o_free,     // register can take a result
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [15:0]         o_m_tdata,  // [7:0] data_byte, [11:8] frame_opcode,
                                            // [12] frame_fin, [15:13] zero
    output logic [1:0]          o_m_tuser,  // [1:0] event_kind
    output logic                o_m_tlast   // last_byte
);
    import wsd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_m_tready;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {3'b000, r_res.fin, r_res.opcode, r_res.data};
    assign o_m_tuser  = r_res.kind;
    assign o_m_tlast  = r_res.last;

endmodule

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Self-checking bench for the WebSocket frame deframer: frames are built as
// byte streams, pushed through the slave side in random bursts, and every
// event leaving the master side is matched against a cycle-free predictor
// of the frame parser. A close frame ends the stream; trailing bytes must be
// swallowed without events.
// ============================================================================

module tb_top;

    import wsd_pkg::*;

    // Opcodes the parser does not react to
    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_RSVD = 4'hF;

    localparam int RANDOM_BYTES = 1950;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 10;

    typedef enum int {FORM_SHORT, FORM_EXT16, FORM_EXT64} t_len_form;
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} t_rx_mode;

    // One byte waiting to be sent; drain holds it until all events are in
    typedef struct {
        logic [7:0] b;
        bit         drain;
    } t_rx_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = 8'h00;    // [7:0] rx_byte
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [15:0] o_m_tdata;            // [7:0] data_byte, [11:8] frame_opcode,
                                       // [12] frame_fin, [15:13] zero
    logic [1:0]  o_m_tuser;            // [1:0] event_kind
    logic        o_m_tlast;            // last_byte

    websocket_frame_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Frame parser predictor
    // ------------------------------------------------------------------
    t_phase      m_phase    = PH_HDR0;
    logic [3:0]  m_opc      = 4'h0;
    logic        m_fin      = 1'b0;
    logic        m_masked   = 1'b0;
    logic [63:0] m_remain   = 64'd0;
    logic [3:0]  m_ext_left = 4'd0;
    logic [31:0] m_key      = 32'd0;
    logic [1:0]  m_kpos     = 2'd0;

    t_result     expected_events[$];

    t_rx_item    tx_bytes[$];
    bit          drain_next = 1'b0;

    int unsigned n_bytes = 0;
    int unsigned n_frames = 0;
    int unsigned n_fail = 0;
    int unsigned kind_cnt[4] = '{0, 0, 0, 0};

    task automatic push_event(input t_event kind, input logic [7:0] data,
                              input logic last);
        t_result ev;
        ev.kind   = kind;
        ev.data   = data;
        ev.opcode = m_opc;
        ev.last   = last;
        ev.fin    = m_fin;
        expected_events.insert(expected_events.size(), ev);
    endtask

    // Advance the parser by one received byte and queue any event it gives
    task automatic deframe_byte(input logic [7:0] b);
        logic       len_done;
        logic       hdr_done;
        logic       frame_done;
        logic       is_data;
        logic [7:0] k;
        len_done   = 1'b0;
        hdr_done   = 1'b0;
        frame_done = 1'b0;
        case (m_phase)
            PH_HDR0: begin
                m_fin   = b[7];
                m_opc   = b[3:0];
                m_phase = PH_HDR1;
            end
            PH_HDR1: begin
                m_masked = b[7];
                m_key    = 32'd0;
                m_kpos   = 2'd0;
                if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
                    m_ext_left = (b[6:0] == LEN_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                    m_remain   = 64'd0;
                    m_phase    = PH_EXTLEN;
                end else begin
                    m_remain = 64'(b[6:0]);
                    len_done = 1'b1;
                end
            end
            PH_EXTLEN: begin
                m_remain = {m_remain[55:0], b};
                m_ext_left--;
                len_done = (m_ext_left == 4'd0);
            end
            PH_MASK: begin
                m_key = {m_key[23:0], b};
                m_ext_left--;
                hdr_done = (m_ext_left == 4'd0);
            end
            PH_DATA: begin
                k = 8'(m_key >> (8 * (3 - int'(m_kpos))));
                m_kpos++;
                if (m_remain != 64'd0) m_remain--;
                if (m_opc == OP_TEXT || m_opc == OP_BIN) begin
                    push_event(EV_BYTE, b ^ k, m_remain == 64'd0);
                    if (m_remain == 64'd0) m_phase = PH_HDR0;
                end else begin
                    frame_done = (m_remain == 64'd0);
                end
            end
            default: begin
                // closed: everything is dropped
            end
        endcase

        // Length known: fetch the key or finish the header
        if (len_done) begin
            if (m_masked) begin
                m_ext_left = KEY_BYTES;
                m_phase    = PH_MASK;
            end else begin
                hdr_done = 1'b1;
            end
        end
        if (hdr_done) begin
            if (m_remain == 64'd0) frame_done = 1'b1;
            else m_phase = PH_DATA;
        end

        // End of frame; a data frame only gets here when it is empty
        is_data = (m_opc == OP_TEXT || m_opc == OP_BIN);
        if (frame_done) begin
            if (m_opc == OP_CLOSE) begin
                m_phase = PH_CLOSED;
                push_event(EV_CLOSE, 8'h00, 1'b1);
            end else begin
                m_phase = PH_HDR0;
                if (m_opc == OP_PING) push_event(EV_PONG, 8'h00, 1'b1);
                else if (is_data) push_event(EV_EMPTY, 8'h00, 1'b1);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b);
        t_rx_item it;
        it.b       = b;
        it.drain   = drain_next;
        drain_next = 1'b0;
        tx_bytes.insert(tx_bytes.size(), it);
    endtask

    // Queue one frame: header, extended length, key, random payload
    task automatic queue_frame(input logic fin, input logic [2:0] rsv,
                               input logic [3:0] opc, input logic masked,
                               input t_len_form form, input int len);
        logic [63:0] len64;
        len64 = 64'(len);
        push_byte({fin, rsv, opc});
        case (form)
            FORM_EXT16: begin
                push_byte({masked, LEN_EXT16});
                push_byte(len64[15:8]);
                push_byte(len64[7:0]);
            end
            FORM_EXT64: begin
                push_byte({masked, LEN_EXT64});
                for (int i = 7; i >= 0; i--) push_byte(len64[8*i +: 8]);
            end
            default: push_byte({masked, len64[6:0]});
        endcase
        if (masked) repeat (4) push_byte(8'($urandom));
        repeat (len) push_byte(8'($urandom));
        n_frames++;
    endtask

    task automatic queue_random_frame();
        int unsigned r;
        logic [3:0]  opc;
        t_len_form   form;
        int          len;
        r = $urandom_range(99);
        if (r < 60) begin
            opc = ($urandom_range(1) != 0) ? OP_TEXT : OP_BIN;
        end else if (r < 72) begin
            opc = OP_PING;
        end else if (r < 82) begin
            opc = OP_CONT;
        end else begin
            // reserved and control opcodes other than close
            opc = 4'($urandom_range(3, 15));
            if (opc == OP_CLOSE) opc = OP_RSVD;
        end
        r = $urandom_range(99);
        if (r < 70) begin
            form = FORM_SHORT;
            len  = $urandom_range(0, 12);
        end else if (r < 80) begin
            form = FORM_SHORT;
            len  = $urandom_range(13, 125);
        end else if (r < 90) begin
            form = FORM_EXT16;
            len  = $urandom_range(0, 300);
        end else begin
            form = FORM_EXT64;
            len  = $urandom_range(0, 40);
        end
        queue_frame(1'($urandom_range(1)), 3'($urandom), opc, 1'($urandom_range(1)),
                    form, len);
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;

    always @(posedge i_clk) begin : sender
        logic nxt_valid;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            nxt_valid = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                deframe_byte(i_s_tdata);
                n_bytes++;
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (tx_bytes.size() != 0 &&
                             !(tx_bytes[0].drain && expected_events.size() != 0)) begin
                    i_s_tdata <= tx_bytes[0].b;
                    void'(tx_bytes.pop_front());
                    nxt_valid = 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
            i_s_tvalid <= nxt_valid;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready pattern switches between several modes
    // ------------------------------------------------------------------
    t_rx_mode    rdy_mode = RX_OPEN;
    int unsigned mode_left = 0;
    logic [2:0]  rdy_tick = 3'd0;

    always @(posedge i_clk) begin : receiver
        if (mode_left == 0) begin
            rdy_mode  = t_rx_mode'($urandom_range(3));
            mode_left = $urandom_range(32, 256);
        end else begin
            mode_left--;
        end
        rdy_tick++;
        case (rdy_mode)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_COIN:   i_m_tready <= 1'($urandom_range(1));
            RX_SPARSE: i_m_tready <= ($urandom_range(3) == 0);
            default:   i_m_tready <= (rdy_tick == 3'd0);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: match each event against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            kind_cnt[o_m_tuser]++;
            if (expected_events.size() == 0) begin
                $error("unexpected event: kind %0d data %02h opcode %0h",
                       o_m_tuser, o_m_tdata[7:0], o_m_tdata[11:8]);
                n_fail++;
            end else begin
                want = expected_events.pop_front();
                if (o_m_tuser !== want.kind) begin
                    $error("event_kind mismatch: expected %0d, got %0d",
                           want.kind, o_m_tuser);
                    n_fail++;
                end
                if (o_m_tdata[7:0] !== want.data) begin
                    $error("data_byte mismatch: expected %02h, got %02h",
                           want.data, o_m_tdata[7:0]);
                    n_fail++;
                end
                if (o_m_tdata[11:8] !== want.opcode) begin
                    $error("frame_opcode mismatch: expected %0h, got %0h",
                           want.opcode, o_m_tdata[11:8]);
                    n_fail++;
                end
                if (o_m_tdata[12] !== want.fin) begin
                    $error("frame_fin mismatch: expected %0b, got %0b",
                           want.fin, o_m_tdata[12]);
                    n_fail++;
                end
                if (o_m_tlast !== want.last) begin
                    $error("last_byte mismatch: expected %0b, got %0b",
                           want.last, o_m_tlast);
                    n_fail++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any request moving on either side
    // ------------------------------------------------------------------
    int unsigned idle_cycles = 0;

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : main
        int unsigned start_len;

        // Directed: empty continuation, empty text, masked 16-bit zero length,
        // masked ping with payload, reserved opcode with a 64-bit length
        queue_frame(1'b0, 3'b000, OP_CONT, 1'b0, FORM_SHORT, 0);
        queue_frame(1'b1, 3'b000, OP_TEXT, 1'b0, FORM_SHORT, 0);
        queue_frame(1'b0, 3'b000, OP_BIN,  1'b1, FORM_EXT16, 0);
        queue_frame(1'b1, 3'b000, OP_PING, 1'b1, FORM_SHORT, 1);
        queue_frame(1'b1, 3'b111, OP_RSVD, 1'b0, FORM_EXT64, 1);

        // Random frames; the sender drains the pipeline twice on the way
        start_len  = tx_bytes.size();
        drain_next = 1'b1;
        while (tx_bytes.size() - start_len < RANDOM_BYTES) begin
            if (n_frames == 40) drain_next = 1'b1;
            queue_random_frame();
        end

        // Close ends the stream; what follows must be ignored
        queue_frame(1'b1, 3'b000, OP_CLOSE, 1'b1, FORM_SHORT, 2);
        push_byte({1'b1, 3'b000, OP_TEXT});
        push_byte(8'h01);
        repeat (4) push_byte(8'($urandom));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (tx_bytes.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d frames, %0d bytes accepted", n_frames, n_bytes);
        $display("events: %0d payload, %0d empty, %0d pong, %0d close",
                 kind_cnt[EV_BYTE], kind_cnt[EV_EMPTY], kind_cnt[EV_PONG], kind_cnt[EV_CLOSE]);
        if (n_fail == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
